// ===== rtl/eeo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elastic ease-out package
// Shared types, fixed-point constants and pipeline depths for the block.
// ----------------------------------------------------------------------------
package eeo_pkg;

	localparam int SINE_TABLE_BITS = 10;

	localparam int XQW = 20;
	localparam int NXW = 37;
	localparam int DXW = 17;
	localparam int PQW = SINE_TABLE_BITS + 2;
	localparam int NPW = SINE_TABLE_BITS + 22;
	localparam int DPW = 19;

	localparam int EXP_TERMS  = 9;
	localparam int EXP_STAGES = 3 * EXP_TERMS;
	localparam int MIX_STAGES = 4;
	localparam int LATENCY    = 1 + XQW + 1 + EXP_STAGES + 1 + MIX_STAGES;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic signed [33:0] SA1 = 34'sd1686629713;
	localparam logic signed [33:0] SA3 = -34'sd693598670;
	localparam logic signed [33:0] SA5 = 34'sd85569300;
	localparam logic signed [33:0] SA7 = -34'sd5026994;
	localparam logic signed [33:0] SA9 = 34'sd172272;

	typedef struct packed {
		logic signed [17:0] elapsed_time;
		logic        [15:0] duration;
		logic signed [31:0] start_value;
		logic signed [31:0] change_amount;
	} in_t;

	typedef struct packed {
		logic signed [31:0] eased_value;
		logic               saturated;
	} out_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_END,
		MODE_EASE
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] b;
		logic signed [31:0] c;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [NXW-1:0]   remx;
		logic [DXW-1:0]   dx;
		logic [XQW-1:0]   qx;
		logic [NPW-1:0]   remp;
		logic [DPW-1:0]   dp;
		logic [PQW-1:0]   qp;
	} div_t;

	typedef struct packed {
		side_t              side;
		logic [3:0]         k;
		logic [29:0]        ay;
		logic [30:0]        eacc;
		logic [60:0]        eprod;
		logic [30:0]        em;
		logic [30:0]        eq;
		logic [1:0]         quad;
		logic [30:0]        u;
		logic [30:0]        u2;
		logic signed [33:0] sacc;
		logic signed [65:0] sprod;
		logic signed [31:0] s;
	} wave_t;

	typedef struct packed {
		side_t              side;
		logic [30:0]        env;
		logic signed [31:0] s;
	} mix_t;

endpackage
`default_nettype wire

// ===== rtl/elastic_ease_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elastic ease-out
// Fixed-point elastic ease-out curve, one item per clock.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and busy never rises. Each
// result appears on result with done high for one cycle; the receiver must
// take it then. The latency from its start transfer comes from the 20-stage
// pipelined divider that forms the time fraction, from the 27 stages of the
// exponential series, each of its nine terms using one multiply, one
// reciprocal multiply and one correction stage, and from the combiner.
module elastic_ease_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  eeo_pkg::in_t  item,
	output logic          done,
	output eeo_pkg::out_t result
);
	import eeo_pkg::*;

	logic  div_valid, wave_valid;
	div_t  div_data;
	mix_t  wave_data;

	assign busy = 1'b0;

	eeo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_item  (item),
		.out_valid(div_valid),
		.out_data (div_data)
	);

	eeo_wave u_wave (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_data  (div_data),
		.out_valid(wave_valid),
		.out_data (wave_data)
	);

	eeo_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (wave_valid),
		.in_data  (wave_data),
		.out_valid(done),
		.out_data (result)
	);

endmodule
`default_nettype wire

// ===== rtl/eeo_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elastic ease-out divider
// Pipelined restoring division giving the rounded envelope and phase indices.
// ----------------------------------------------------------------------------
module eeo_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  eeo_pkg::in_t  in_item,
	output logic          out_valid,
	output eeo_pkg::div_t out_data
);
	import eeo_pkg::*;

	logic [XQW:0] vld_s;
	div_t         stage_s [0:XQW];
	div_t         first;

	always_comb begin
		logic [15:0]    t16;
		logic [NXW-1:0] tx;
		logic [NPW-1:0] tp;
		logic [NPW-1:0] dd;
		first = '0;
		t16 = in_item.elapsed_time[15:0];
		if (in_item.elapsed_time <= 18'sd0) begin
			first.side.mode = MODE_HOLD;
		end else if (in_item.duration == 16'd0 ||
				in_item.elapsed_time[16:0] >= {1'b0, in_item.duration}) begin
			first.side.mode = MODE_END;
		end else begin
			first.side.mode = MODE_EASE;
		end
		first.side.b = in_item.start_value;
		first.side.c = in_item.change_amount;
		tx = NXW'(t16) << 16;
		first.remx = (tx << 4) + (tx << 2) + NXW'(in_item.duration);
		first.dx = {in_item.duration, 1'b0};
		tp = NPW'(t16) << SINE_TABLE_BITS;
		dd = NPW'(in_item.duration);
		first.remp = (tp << 4) + (tp << 2) + (dd << 1) + dd;
		first.dp = (DPW'(in_item.duration) << 2) + (DPW'(in_item.duration) << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[XQW-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		stage_s[0] <= first;
	end

	for (genvar i = 0; i < XQW; i++) begin : g_bit
		localparam int J = XQW - 1 - i;
		div_t           nxt;
		logic [NXW-1:0] candx;
		logic [NPW-1:0] candp;

		always_comb begin
			nxt = stage_s[i];
			candx = NXW'(stage_s[i].dx) << J;
			candp = NPW'(stage_s[i].dp) << J;
			if (stage_s[i].remx >= candx) begin
				nxt.remx = stage_s[i].remx - candx;
				nxt.qx[J] = 1'b1;
			end
			if (J < PQW) begin
				if (stage_s[i].remp >= candp) begin
					nxt.remp = stage_s[i].remp - candp;
					nxt.qp[J % PQW] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			stage_s[i+1] <= nxt;
		end
	end

	assign out_valid = vld_s[XQW];
	assign out_data  = stage_s[XQW];

endmodule
`default_nettype wire

// ===== rtl/eeo_wave.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elastic ease-out waveform
// Exponential envelope and quarter-wave sine series in a shared pipeline.
// ----------------------------------------------------------------------------
module eeo_wave (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  eeo_pkg::div_t in_data,
	output logic          out_valid,
	output eeo_pkg::mix_t out_data
);
	import eeo_pkg::*;

	logic [EXP_STAGES+1:0] vld_s;
	wave_t                 wave_s [0:EXP_STAGES];
	wave_t                 first;
	mix_t                  env_s;

	always_comb begin
		logic [SINE_TABLE_BITS-1:0] ph;
		logic [45:0]                yp;
		first = '0;
		first.side = in_data.side;
		first.k = in_data.qx[19:16];
		yp = 46'(in_data.qx[15:0]) * 46'(LN2_Q30);
		first.ay = 30'(yp >> 16);
		ph = in_data.qp[SINE_TABLE_BITS-1:0]
			- SINE_TABLE_BITS'(1 << (SINE_TABLE_BITS - 2));
		first.quad = ph[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
		first.u = 31'(ph[SINE_TABLE_BITS-3:0]) << (30 - (SINE_TABLE_BITS - 2));
		if (first.quad[0]) begin
			first.u = Q30_ONE - first.u;
		end
		first.eacc = Q30_ONE;
		first.sacc = SA9;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[EXP_STAGES:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		wave_s[0] <= first;
	end

	for (genvar e = 0; e < EXP_STAGES; e++) begin : g_step
		localparam int STEP = e / 3;
		localparam int PH   = e % 3;
		localparam int NDIV = EXP_TERMS - STEP;
		localparam logic [32:0] RECIP = 33'((64'd1 << 32) / NDIV);
		localparam logic signed [33:0] SCOEF =
			(e == 2) ? SA7 : (e == 4) ? SA5 : (e == 6) ? SA3 : SA1;
		wave_t nxt;

		always_comb begin
			logic [30:0]        emc;
			logic [63:0]        qr;
			logic [34:0]        qn;
			logic [34:0]        rem;
			logic [61:0]        uu;
			logic signed [65:0] v;
			nxt = wave_s[e];
			emc = '0;
			qr = '0;
			qn = '0;
			rem = '0;
			uu = '0;
			v = '0;
			case (PH)
				0: begin
					nxt.eprod = 61'(wave_s[e].ay) * 61'(wave_s[e].eacc);
				end
				1: begin
					emc = 31'((wave_s[e].eprod + 61'(Q30_ONE - 31'd1)) >> 30);
					qr = 64'(emc) * 64'(RECIP);
					nxt.em = emc;
					nxt.eq = 31'(qr >> 32);
				end
				default: begin
					qn = 35'(wave_s[e].eq) * 35'(NDIV);
					rem = 35'(wave_s[e].em) - qn;
					nxt.eacc = Q30_ONE - (wave_s[e].eq + 31'(rem >= 35'(NDIV)));
				end
			endcase
			case (e)
				0: begin
					uu = 62'(wave_s[e].u) * 62'(wave_s[e].u);
					nxt.u2 = 31'(uu >> 30);
				end
				1, 3, 5, 7: begin
					nxt.sprod = 66'(wave_s[e].sacc) * 66'($signed({1'b0, wave_s[e].u2}));
				end
				2, 4, 6, 8: begin
					nxt.sacc = SCOEF + 34'(wave_s[e].sprod >>> 30);
				end
				9: begin
					nxt.sprod = 66'(wave_s[e].sacc) * 66'($signed({1'b0, wave_s[e].u}));
				end
				10: begin
					v = wave_s[e].sprod >>> 30;
					if (v < 0) begin
						v = '0;
					end else if (v > 66'sd1073741824) begin
						v = 66'sd1073741824;
					end
					nxt.s = wave_s[e].quad[1] ? -32'(v) : 32'(v);
				end
				default: begin
				end
			endcase
		end

		always_ff @(posedge clk) begin
			wave_s[e+1] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		env_s.side <= wave_s[EXP_STAGES].side;
		env_s.env  <= wave_s[EXP_STAGES].eacc >> wave_s[EXP_STAGES].k;
		env_s.s    <= wave_s[EXP_STAGES].s;
	end

	assign out_valid = vld_s[EXP_STAGES+1];
	assign out_data  = env_s;

endmodule
`default_nettype wire

// ===== rtl/eeo_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elastic ease-out combiner
// Scales the wave by the change, adds start and change, and saturates.
// ----------------------------------------------------------------------------
module eeo_mix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  eeo_pkg::mix_t in_data,
	output logic          out_valid,
	output eeo_pkg::out_t out_data
);
	import eeo_pkg::*;

	logic [MIX_STAGES-1:0] vld_s;
	side_t                 side_s1, side_s2;
	logic signed [31:0]    es_s1;
	logic signed [63:0]    cprod_s2;
	logic signed [34:0]    part_s3;
	logic signed [33:0]    term_s3;
	out_t                  res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[MIX_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] pe;
		logic signed [63:0] tr;
		logic signed [34:0] sum;
		pe = 64'($signed({1'b0, in_data.env})) * 64'(in_data.s);
		side_s1 <= in_data.side;
		es_s1 <= 32'(pe >>> 30);

		side_s2 <= side_s1;
		cprod_s2 <= 64'(side_s1.c) * 64'(es_s1);

		tr = (cprod_s2 + 64'sd536870912) >>> 30;
		term_s3 <= (side_s2.mode == MODE_EASE) ? 34'(tr) : 34'sd0;
		part_s3 <= 35'(side_s2.b) + ((side_s2.mode == MODE_HOLD) ? 35'sd0 : 35'(side_s2.c));

		sum = part_s3 + 35'(term_s3);
		if (sum > 35'sd2147483647) begin
			res_s4.eased_value <= 32'sh7FFF_FFFF;
			res_s4.saturated <= 1'b1;
		end else if (sum < -35'sd2147483648) begin
			res_s4.eased_value <= 32'sh8000_0000;
			res_s4.saturated <= 1'b1;
		end else begin
			res_s4.eased_value <= 32'(sum);
			res_s4.saturated <= 1'b0;
		end
	end

	assign out_valid = vld_s[MIX_STAGES-1];
	assign out_data  = res_s4;

endmodule
`default_nettype wire

// ===== rtl/eeo_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elastic ease-out checker
// Port-level checks on transfer timing and result values.
// ----------------------------------------------------------------------------
module eeo_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input eeo_pkg::in_t  item,
	input logic          done,
	input eeo_pkg::out_t result
);
	import eeo_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy rose although the pipeline never stalls");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("an accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("a result appeared without a matching transfer");

	a_not_started: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.elapsed_time <= 18'sd0) |-> ##LATENCY
		(done && !result.saturated &&
		result.eased_value == $past(item.start_value, LATENCY)))
		else $error("an item before its start did not return the start value");

	a_sat_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
		(result.eased_value == 32'sh7FFF_FFFF || result.eased_value == 32'sh8000_0000))
		else $error("saturated result is not at a range end");

endmodule

bind elastic_ease_out eeo_checker u_eeo_checker (.*);
`default_nettype wire

// ===== tb/elastic_ease_out_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elastic ease-out testbench
// Drives directed and random items into the block, predicts each eased value
// in fixed point and compares every result transfer with the oldest
// prediction through a small scoreboard.
// ----------------------------------------------------------------------------

class ease_scoreboard;
	eeo_pkg::out_t pending[$];
	int errors;

	static function longint fl_shift(longint v, int s);
		return v >>> s;
	endfunction

	static function longint quarter_wave(longint u);
		longint u2, acc;
		u2 = (u * u) >>> 30;
		acc = 172272;
		acc = -5026994 + fl_shift(acc * u2, 30);
		acc = 85569300 + fl_shift(acc * u2, 30);
		acc = -693598670 + fl_shift(acc * u2, 30);
		acc = 1686629713 + fl_shift(acc * u2, 30);
		acc = fl_shift(acc * u, 30);
		if (acc < 0) acc = 0;
		if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
		return acc;
	endfunction

	static function longint decay(longint frac16);
		longint y, acc, one;
		one = 64'sd1 << 30;
		y = -(((frac16 << 14) * 64'sd744261118) >>> 30);
		acc = one;
		for (int n = 9; n >= 1; n--) begin
			longint p;
			p = fl_shift(y * acc, 30);
			acc = one + p / n;
		end
		if (acc > one) acc = one;
		if (acc < 0) acc = 0;
		return acc;
	endfunction

	static function eeo_pkg::out_t clip(longint v);
		eeo_pkg::out_t r;
		r.saturated = 1'b0;
		if (v > 64'sd2147483647) begin
			v = 64'sd2147483647;
			r.saturated = 1'b1;
		end else if (v < -64'sd2147483648) begin
			v = -64'sd2147483648;
			r.saturated = 1'b1;
		end
		r.eased_value = v[31:0];
		return r;
	endfunction

	static function eeo_pkg::out_t ease_value(eeo_pkg::in_t it);
		longint t, d, b, c, x, k, env, num, den, p, quad, low_bits, u, s, es, term;
		t = it.elapsed_time;
		d = it.duration;
		b = it.start_value;
		c = it.change_amount;
		if (t <= 0) return clip(b);
		if (d == 0 || t >= d) return clip(b + c);
		x = (2 * ((10 * t) << 16) + d) / (2 * d);
		k = x >> 16;
		env = decay(x & 64'hFFFF);
		env = env >> (k > 40 ? 40 : k);
		num = (10 * t) << eeo_pkg::SINE_TABLE_BITS;
		den = 3 * d;
		p = (2 * num + den) / (2 * den);
		p = (p - (64'sd1 << (eeo_pkg::SINE_TABLE_BITS - 2)))
			& ((64'sd1 << eeo_pkg::SINE_TABLE_BITS) - 1);
		quad = p >> (eeo_pkg::SINE_TABLE_BITS - 2);
		low_bits = p & ((64'sd1 << (eeo_pkg::SINE_TABLE_BITS - 2)) - 1);
		u = low_bits << (30 - (eeo_pkg::SINE_TABLE_BITS - 2));
		if (quad == 1 || quad == 3) u = (64'sd1 << 30) - u;
		s = quarter_wave(u);
		if (quad >= 2) s = -s;
		es = fl_shift(env * s, 30);
		term = fl_shift(c * es + (64'sd1 << 29), 30);
		return clip(term + c + b);
	endfunction

	function void note_item(eeo_pkg::in_t it);
		pending.push_back(ease_value(it));
	endfunction

	function void check_result(eeo_pkg::out_t r);
		eeo_pkg::out_t e;
		if (pending.size() == 0) begin
			$error("result %h with no prediction waiting", r);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (r.eased_value !== e.eased_value) begin
			$error("eased_value expected %0d actual %0d", e.eased_value, r.eased_value);
			errors++;
		end
		if (r.saturated !== e.saturated) begin
			$error("saturated expected %0b actual %0b", e.saturated, r.saturated);
			errors++;
		end
	endfunction
endclass

module elastic_ease_out_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	eeo_pkg::in_t item = '0;
	eeo_pkg::out_t result;

	ease_scoreboard board = new();
	int idle_pct = 10;
	int quiet = 0;

	elastic_ease_out uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_result(result);
			if ((start && !busy) || done) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet > 2000) begin
				$display("** elastic_ease_out: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_item(eeo_pkg::in_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_item(it);
		@(negedge clk);
	endtask

	function automatic eeo_pkg::in_t random_item();
		eeo_pkg::in_t it;
		it.start_value = $urandom;
		it.change_amount = $urandom;
		if ($urandom_range(3) == 0) begin
			it.start_value = $signed(it.start_value) >>> $urandom_range(20);
			it.change_amount = $signed(it.change_amount) >>> $urandom_range(20);
		end
		case ($urandom_range(9))
			0: begin
				it.elapsed_time = 18'($urandom);
				it.duration = 16'($urandom);
			end
			1: begin
				it.duration = 16'($urandom_range(8));
				it.elapsed_time = 18'($urandom_range(9));
			end
			default: begin
				it.duration = 16'($urandom_range(65535, 1));
				it.elapsed_time = 18'($urandom_range(it.duration));
			end
		endcase
		return it;
	endfunction

	function automatic eeo_pkg::in_t make_item(int t, int d, int b, int c);
		eeo_pkg::in_t it;
		it.elapsed_time = 18'(t);
		it.duration = 16'(d);
		it.start_value = b;
		it.change_amount = c;
		return it;
	endfunction

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_item(make_item(0, 100, 32'sh0001_0000, 32'sh0005_0000));
		send_item(make_item(-131072, 65535, 32'sh8000_0000, 32'sh7FFF_FFFF));
		send_item(make_item(131071, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		send_item(make_item(5, 0, 32'sh8000_0000, 32'sh8000_0000));
		send_item(make_item(100, 100, 32'sh7FFF_FFFF, 1));
		send_item(make_item(1, 65535, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		send_item(make_item(1, 65535, 32'sh8000_0000, 32'sh8000_0000));
		send_item(make_item(1, 2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		send_item(make_item(1, 2, 32'sh8000_0000, 32'sh8000_0000));
		send_item(make_item(65534, 65535, 0, 32'sh0010_0000));
		send_item(make_item(30, 100, 32'sh0001_0000, 32'sh8000_0000));
		send_item(make_item(7, 40, -32'sh0003_0000, 32'sh0100_0000));
		send_item(make_item(99, 1000, 0, 32'sh7FFF_FFFF));
		send_item(make_item(131071, 65535, 5, -7));
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 10 : (ph == 1) ? 47 : 0;
			for (int i = 0; i < 460; i++) send_item(random_item());
		end
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (eeo_pkg::LATENCY + 10) @(posedge clk);
		if (board.errors == 0) begin
			$display("** elastic_ease_out: PASSED **");
		end else begin
			$display("** elastic_ease_out: FAILED **");
		end
		$finish;
	end
endmodule
`default_nettype wire
